### src/assert_macros.svh
// Assertion macros shared by the RTL files; clk and rst_n are taken from the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/lik_pkg.sv
// Types, constants and helper functions shared by the leg IK modules.
`default_nettype none

package lik_pkg;

    localparam int AW       = 50;           // atan2 operand width
    localparam int ANG_W    = 25;           // angle width, degrees * 2^16
    localparam int STEPS    = 20;           // CORDIC iterations
    localparam logic signed [ANG_W-1:0] DEG45  = 25'sd2949120;
    localparam logic signed [ANG_W-1:0] DEG90  = 25'sd5898240;
    localparam logic signed [ANG_W-1:0] DEG180 = 25'sd11796480;

    localparam logic [1:0] REG_COXA  = 2'd0;
    localparam logic [1:0] REG_FEMUR = 2'd1;
    localparam logic [1:0] REG_TIBIA = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_MXX, OP_MYY, OP_SQR, OP_H, OP_MHH, OP_MVV,
        OP_DFF, OP_TT, OP_SP, OP_SM, OP_CHK, OP_MR, OP_SQS, OP_MHC,
        OP_MVS, OP_MVC, OP_MHS, OP_FY, OP_GY, OP_GX, OP_AT1, OP_AT2,
        OP_AT3, OP_FIN
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic sq_done;
        logic at_done;
        logic unreach;
    } status_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [22:0] atan_tab(input logic [4:0] i);
        logic [22:0] t;
        case (i)
            5'd0:    t = 23'd2949120;
            5'd1:    t = 23'd1740967;
            5'd2:    t = 23'd919879;
            5'd3:    t = 23'd466945;
            5'd4:    t = 23'd234379;
            5'd5:    t = 23'd117304;
            5'd6:    t = 23'd58666;
            5'd7:    t = 23'd29335;
            5'd8:    t = 23'd14668;
            5'd9:    t = 23'd7334;
            5'd10:   t = 23'd3667;
            5'd11:   t = 23'd1833;
            5'd12:   t = 23'd917;
            5'd13:   t = 23'd458;
            5'd14:   t = 23'd229;
            5'd15:   t = 23'd115;
            5'd16:   t = 23'd57;
            5'd17:   t = 23'd29;
            5'd18:   t = 23'd14;
            5'd19:   t = 23'd7;
            default: t = 23'd0;
        endcase
        return t;
    endfunction

    // fixed-point degrees to whole degrees, truncated toward zero
    function automatic logic signed [10:0] trunc_deg(input logic signed [26:0] a);
        logic signed [26:0] t;
        t = a + (a[26] ? 27'sd65535 : 27'sd0);
        return t[26:16];
    endfunction

endpackage

`default_nettype wire

### src/lik_sqrt.sv
// Bit-pair restoring integer square root, one result bit per cycle.
`default_nettype none

module lik_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] n,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (start)
        begin
            rem_next  = n;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

`default_nettype wire

### src/lik_atan.sv
// Iterative atan2 in degrees: octant fold, shift normalize, 20-step CORDIC.
`default_nettype none

`include "assert_macros.svh"

module lik_atan (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [lik_pkg::AW-1:0]     y,
    input  wire logic signed [lik_pkg::AW-1:0]     x,
    output logic                                   done,
    output logic signed [lik_pkg::ANG_W-1:0]       angle
);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_NORM = 4'b0010,
        A_ITER = 4'b0100,
        A_POST = 4'b1000
    } astate_t;

    astate_t state_reg, state_next;
    logic [lik_pkg::AW-1:0] big_reg, big_next, small_reg, small_next;
    logic signed [32:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [lik_pkg::ANG_W-1:0] z_reg, z_next, ang_reg, ang_next;
    logic [4:0] i_reg, i_next;
    logic swap_reg, swap_next, xneg_reg, xneg_next, yneg_reg, yneg_next;
    logic done_reg, done_next;

    logic [lik_pkg::AW-1:0] ax, ay;
    logic signed [lik_pkg::ANG_W-1:0] a, tab;

    always_comb
    begin
        state_next = state_reg;
        big_next   = big_reg;
        small_next = small_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        z_next     = z_reg;
        i_next     = i_reg;
        swap_next  = swap_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        ang_next   = ang_reg;
        done_next  = 1'b0;
        ax  = x[lik_pkg::AW-1] ? lik_pkg::AW'(-x) : lik_pkg::AW'(x);
        ay  = y[lik_pkg::AW-1] ? lik_pkg::AW'(-y) : lik_pkg::AW'(y);
        tab = lik_pkg::ANG_W'({2'b00, lik_pkg::atan_tab(i_reg)});
        a   = z_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    swap_next  = ay > ax;
                    xneg_next  = x[lik_pkg::AW-1];
                    yneg_next  = y[lik_pkg::AW-1];
                    big_next   = (ay > ax) ? ay : ax;
                    small_next = (ay > ax) ? ax : ay;
                    if (ax == '0 || ay == '0)
                    begin
                        z_next     = '0;
                        state_next = A_POST;
                    end
                    else if (ax == ay)
                    begin
                        z_next     = lik_pkg::DEG45;
                        state_next = A_POST;
                    end
                    else
                    begin
                        state_next = A_NORM;
                    end
                end
            end
            A_NORM:
            begin
                if (|big_reg[lik_pkg::AW-1:30])
                begin
                    big_next   = big_reg >> 1;
                    small_next = small_reg >> 1;
                end
                else if (big_reg[29] == 1'b0)
                begin
                    big_next   = big_reg << 1;
                    small_next = small_reg << 1;
                end
                else
                begin
                    cx_next    = {3'b000, big_reg[29:0]};
                    cy_next    = {3'b000, small_reg[29:0]};
                    z_next     = '0;
                    i_next     = '0;
                    state_next = A_ITER;
                end
            end
            A_ITER:
            begin
                if (i_reg == 5'(lik_pkg::STEPS) || cy_reg == '0)
                begin
                    state_next = A_POST;
                end
                else
                begin
                    if (!cy_reg[32])
                    begin
                        cx_next = cx_reg + (cy_reg >>> i_reg);
                        cy_next = cy_reg - (cx_reg >>> i_reg);
                        z_next  = z_reg + tab;
                    end
                    else
                    begin
                        cx_next = cx_reg - (cy_reg >>> i_reg);
                        cy_next = cy_reg + (cx_reg >>> i_reg);
                        z_next  = z_reg - tab;
                    end
                    i_next = i_reg + 5'd1;
                end
            end
            A_POST:
            begin
                if (z_reg < 0)
                    a = '0;
                else if (z_reg > lik_pkg::DEG45)
                    a = lik_pkg::DEG45;
                if (swap_reg)
                    a = lik_pkg::DEG90 - a;
                if (xneg_reg)
                    a = lik_pkg::DEG180 - a;
                if (yneg_reg)
                    a = -a;
                ang_next   = a;
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        big_reg   <= big_next;
        small_reg <= small_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        z_reg     <= z_next;
        i_reg     <= i_next;
        swap_reg  <= swap_next;
        xneg_reg  <= xneg_next;
        yneg_reg  <= yneg_next;
        ang_reg   <= ang_next;
    end

    assign done  = done_reg;
    assign angle = ang_reg;

    `ASSERT_IMP(a_angle_range, done_reg, ang_reg <= lik_pkg::DEG180 && ang_reg >= -lik_pkg::DEG180)
    `ASSERT_NXT(a_start_leaves_idle, start && state_reg == A_IDLE, state_reg != A_IDLE)

endmodule

`default_nettype wire

### src/lik_datapath.sv
// Leg IK datapath: shared multiplier, working registers, sqrt and atan2 units.
`default_nettype none

module lik_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lik_pkg::cmd_t       cmd,
    output lik_pkg::status_t         status,
    input  wire logic                operation,
    input  wire logic signed [15:0]  target_x,
    input  wire logic signed [15:0]  target_y,
    input  wire logic signed [15:0]  lift_offset,
    input  wire logic [13:0]         coxa_offset,
    input  wire logic [13:0]         femur_length,
    input  wire logic [13:0]         tibia_length,
    output logic signed [8:0]        coxa_deg,
    output logic signed [8:0]        femur_deg,
    output logic signed [9:0]        tibia_servo_deg,
    output logic                     unreachable
);

    localparam int AW = lik_pkg::AW;
    localparam int NW = lik_pkg::ANG_W;

    // foot position and stored angles
    logic signed [15:0] px_reg, py_reg;
    logic signed [8:0]  coxa_reg, fem_deg_reg;
    logic signed [9:0]  servo_reg;
    logic               unr_out_reg;

    logic signed [15:0] v_reg;
    logic signed [65:0] prod_reg, acc_reg;
    logic [15:0]        h_reg;
    logic [31:0]        d_reg;
    logic [29:0]        f2_reg, t2_reg, sp2_reg, sm2_reg, s_reg;
    logic signed [31:0] c_reg;
    logic signed [AW-1:0] fx_reg, fy_reg, gx_reg, gy_reg;
    logic signed [NW-1:0] fem_reg, a2_reg;
    logic               unreach_reg;

    logic signed [16:0] sum_x, sum_y;
    logic signed [15:0] nx, ny;
    logic signed [32:0] ma, mb;
    logic signed [65:0] mprod, acc_sum, acc_dif;
    logic [14:0]        ft_sum;
    logic signed [14:0] ft_dif;
    logic [31:0]        r32;
    logic               sel;
    logic               sq_start, at_start;
    logic [63:0]        sq_n;
    logic [31:0]        sq_root;
    logic               sq_done, at_done;
    logic signed [AW-1:0] at_y, at_x;
    logic signed [NW-1:0] at_ang;
    logic signed [26:0] tib;
    logic signed [10:0] coxa_t, fem_t, tib_t, servo_t;

    function automatic logic signed [15:0] sat17(input logic signed [16:0] s);
        logic signed [15:0] r;
        if (s[16] != s[15])
            r = s[16] ? 16'sh8000 : 16'sh7FFF;
        else
            r = s[15:0];
        return r;
    endfunction

    always_comb
    begin
        sum_x  = {target_x[15], target_x} + {px_reg[15], px_reg};
        sum_y  = {target_y[15], target_y} + {py_reg[15], py_reg};
        nx     = operation ? sat17(sum_x) : target_x;
        ny     = operation ? sat17(sum_y) : target_y;
        ft_sum = {1'b0, femur_length} + {1'b0, tibia_length};
        ft_dif = $signed({1'b0, femur_length}) - $signed({1'b0, tibia_length});
        sel    = (h_reg != '0) && (s_reg != '0);
        r32    = sq_root;
        acc_sum = acc_reg + prod_reg;
        acc_dif = acc_reg - prod_reg;
        ma = '0;
        mb = '0;
        case (cmd.op)
            lik_pkg::OP_MXX:
            begin
                ma = 33'(px_reg); mb = 33'(px_reg);
            end
            lik_pkg::OP_MYY:
            begin
                ma = 33'(py_reg); mb = 33'(py_reg);
            end
            lik_pkg::OP_MHH:
            begin
                ma = {17'b0, h_reg}; mb = {17'b0, h_reg};
            end
            lik_pkg::OP_MVV:
            begin
                ma = 33'(v_reg); mb = 33'(v_reg);
            end
            lik_pkg::OP_DFF:
            begin
                ma = {19'b0, femur_length}; mb = {19'b0, femur_length};
            end
            lik_pkg::OP_TT:
            begin
                ma = {19'b0, tibia_length}; mb = {19'b0, tibia_length};
            end
            lik_pkg::OP_SP:
            begin
                ma = {18'b0, ft_sum}; mb = {18'b0, ft_sum};
            end
            lik_pkg::OP_SM:
            begin
                ma = 33'(ft_dif); mb = 33'(ft_dif);
            end
            lik_pkg::OP_MR:
            begin
                ma = $signed({3'b000, sp2_reg}) - $signed({1'b0, d_reg});
                mb = $signed({1'b0, d_reg}) - $signed({3'b000, sm2_reg});
            end
            lik_pkg::OP_MHC:
            begin
                ma = {17'b0, h_reg}; mb = 33'(c_reg);
            end
            lik_pkg::OP_MVS:
            begin
                ma = 33'(v_reg); mb = {3'b000, s_reg};
            end
            lik_pkg::OP_MVC:
            begin
                ma = 33'(v_reg); mb = 33'(c_reg);
            end
            lik_pkg::OP_MHS:
            begin
                ma = {17'b0, h_reg}; mb = {3'b000, s_reg};
            end
            lik_pkg::OP_FY:
            begin
                ma = {1'b0, d_reg}; mb = 33'(v_reg);
            end
            lik_pkg::OP_GY:
            begin
                ma = {1'b0, d_reg}; mb = {17'b0, h_reg};
            end
            default:
            begin
                ma = '0; mb = '0;
            end
        endcase
        mprod = ma * mb;

        sq_start = (cmd.op == lik_pkg::OP_SQR) || (cmd.op == lik_pkg::OP_SQS);
        sq_n     = (cmd.op == lik_pkg::OP_SQR) ? acc_sum[63:0] : prod_reg[63:0];

        at_start = (cmd.op == lik_pkg::OP_AT1) || (cmd.op == lik_pkg::OP_AT2)
                || (cmd.op == lik_pkg::OP_AT3);
        case (cmd.op)
            lik_pkg::OP_AT1:
            begin
                at_y = fy_reg; at_x = fx_reg;
            end
            lik_pkg::OP_AT2:
            begin
                at_y = gy_reg; at_x = gx_reg;
            end
            default:
            begin
                at_y = AW'(py_reg); at_x = AW'(px_reg);
            end
        endcase

        tib     = 27'(a2_reg) + 27'(lik_pkg::DEG180) - 27'(fem_reg);
        coxa_t  = lik_pkg::trunc_deg(27'(at_ang));
        fem_t   = lik_pkg::trunc_deg(27'(fem_reg));
        tib_t   = lik_pkg::trunc_deg(tib);
        servo_t = 11'sd90 - tib_t;
    end

    lik_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .n     (sq_n),
        .done  (sq_done),
        .root  (sq_root)
    );

    lik_atan u_atan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (at_start),
        .y     (at_y),
        .x     (at_x),
        .done  (at_done),
        .angle (at_ang)
    );

    // architectural state: foot position, last angles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg      <= '0;
            py_reg      <= '0;
            coxa_reg    <= '0;
            fem_deg_reg <= '0;
            servo_reg   <= '0;
            unr_out_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == lik_pkg::OP_LOAD)
            begin
                px_reg <= nx;
                py_reg <= ny;
            end
            if (cmd.op == lik_pkg::OP_FIN)
            begin
                unr_out_reg <= unreach_reg;
                if (!unreach_reg)
                begin
                    coxa_reg    <= coxa_t[8:0];
                    fem_deg_reg <= fem_t[8:0];
                    servo_reg   <= servo_t[9:0];
                end
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.op != lik_pkg::OP_NONE)
            prod_reg <= mprod;
        case (cmd.op)
            lik_pkg::OP_LOAD: v_reg   <= lift_offset;
            lik_pkg::OP_MYY:  acc_reg <= prod_reg;
            lik_pkg::OP_H:
                h_reg <= (r32[15:0] >= {2'b00, coxa_offset})
                       ? r32[15:0] - {2'b00, coxa_offset}
                       : {2'b00, coxa_offset} - r32[15:0];
            lik_pkg::OP_MVV:  acc_reg <= prod_reg;
            lik_pkg::OP_DFF:  d_reg   <= acc_sum[31:0];
            lik_pkg::OP_TT:   f2_reg  <= prod_reg[29:0];
            lik_pkg::OP_SP:   t2_reg  <= prod_reg[29:0];
            lik_pkg::OP_SM:   sp2_reg <= prod_reg[29:0];
            lik_pkg::OP_CHK:
            begin
                sm2_reg     <= prod_reg[29:0];
                unreach_reg <= (d_reg == '0) || (d_reg > {2'b00, sp2_reg})
                            || (d_reg < {2'b00, prod_reg[29:0]});
            end
            lik_pkg::OP_MR:
                c_reg <= $signed({2'b00, d_reg[29:0]}) + $signed({2'b00, f2_reg})
                       - $signed({2'b00, t2_reg});
            lik_pkg::OP_MHC:  s_reg   <= r32[29:0];
            lik_pkg::OP_MVS:  acc_reg <= prod_reg;
            lik_pkg::OP_MVC:  fx_reg  <= sel ? acc_dif[AW-1:0] : acc_sum[AW-1:0];
            lik_pkg::OP_MHS:  acc_reg <= prod_reg;
            lik_pkg::OP_FY:   fy_reg  <= sel ? acc_sum[AW-1:0] : acc_dif[AW-1:0];
            lik_pkg::OP_GY:   gy_reg  <= AW'((prod_reg <<< 1) - 66'(fy_reg));
            lik_pkg::OP_GX:   gx_reg  <= AW'((prod_reg <<< 1) - 66'(fx_reg));
            lik_pkg::OP_AT2:  fem_reg <= at_ang;
            lik_pkg::OP_AT3:  a2_reg  <= at_ang;
            default:
            begin
            end
        endcase
    end

    assign status.sq_done  = sq_done;
    assign status.at_done  = at_done;
    assign status.unreach  = unreach_reg;

    assign coxa_deg        = coxa_reg;
    assign femur_deg       = fem_deg_reg;
    assign tibia_servo_deg = servo_reg;
    assign unreachable     = unr_out_reg;

endmodule

`default_nettype wire

### src/lik_ctrl.sv
// Leg IK controller: sequences datapath operations and runs both handshakes.
`default_nettype none

`include "assert_macros.svh"

module lik_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lik_pkg::cmd_t           cmd,
    input  wire lik_pkg::status_t   status
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_WAIT = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    lik_pkg::op_t  op_reg, op_next, op_succ;
    logic          out_valid_reg, out_valid_next;
    logic          waits;

    always_comb
    begin
        case (op_reg)
            lik_pkg::OP_MXX: op_succ = lik_pkg::OP_MYY;
            lik_pkg::OP_MYY: op_succ = lik_pkg::OP_SQR;
            lik_pkg::OP_SQR: op_succ = lik_pkg::OP_H;
            lik_pkg::OP_H:   op_succ = lik_pkg::OP_MHH;
            lik_pkg::OP_MHH: op_succ = lik_pkg::OP_MVV;
            lik_pkg::OP_MVV: op_succ = lik_pkg::OP_DFF;
            lik_pkg::OP_DFF: op_succ = lik_pkg::OP_TT;
            lik_pkg::OP_TT:  op_succ = lik_pkg::OP_SP;
            lik_pkg::OP_SP:  op_succ = lik_pkg::OP_SM;
            lik_pkg::OP_SM:  op_succ = lik_pkg::OP_CHK;
            lik_pkg::OP_CHK: op_succ = lik_pkg::OP_MR;
            lik_pkg::OP_MR:  op_succ = lik_pkg::OP_SQS;
            lik_pkg::OP_SQS: op_succ = lik_pkg::OP_MHC;
            lik_pkg::OP_MHC: op_succ = lik_pkg::OP_MVS;
            lik_pkg::OP_MVS: op_succ = lik_pkg::OP_MVC;
            lik_pkg::OP_MVC: op_succ = lik_pkg::OP_MHS;
            lik_pkg::OP_MHS: op_succ = lik_pkg::OP_FY;
            lik_pkg::OP_FY:  op_succ = lik_pkg::OP_GY;
            lik_pkg::OP_GY:  op_succ = lik_pkg::OP_GX;
            lik_pkg::OP_GX:  op_succ = lik_pkg::OP_AT1;
            lik_pkg::OP_AT1: op_succ = lik_pkg::OP_AT2;
            lik_pkg::OP_AT2: op_succ = lik_pkg::OP_AT3;
            lik_pkg::OP_AT3: op_succ = lik_pkg::OP_FIN;
            default:         op_succ = lik_pkg::OP_FIN;
        endcase
        waits = (op_reg == lik_pkg::OP_SQR) || (op_reg == lik_pkg::OP_SQS)
             || (op_reg == lik_pkg::OP_AT1) || (op_reg == lik_pkg::OP_AT2)
             || (op_reg == lik_pkg::OP_AT3);
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cmd.op         = lik_pkg::OP_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = lik_pkg::OP_LOAD;
                    op_next    = lik_pkg::OP_MXX;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                // no intersection: skip straight to the result
                if (op_reg == lik_pkg::OP_MR && status.unreach)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op  = op_reg;
                    op_next = op_succ;
                    if (waits)
                        state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (status.sq_done || status.at_done)
                    state_next = (op_reg == lik_pkg::OP_FIN) ? S_FIN : S_STEP;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = lik_pkg::OP_FIN;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= lik_pkg::OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `ASSERT_NXT(a_result_from_fin, state_reg == S_FIN && (!out_valid_reg || out_ready), out_valid_reg)

endmodule

`default_nettype wire

### src/leg_inverse_kinematics.sv
// Top level of the leg inverse kinematics block: APB registers and controller/datapath.
`default_nettype none

// Three-joint leg IK. Each input transaction gives a foot target (absolute, or a
// displacement added to the stored foot, saturated to 16 bits) and a lift offset,
// all in 1/16 mm; one output transaction returns coxa, femur and tibia servo
// angles in whole degrees, or raises unreachable and repeats the last angles.
// One item is handled at a time, using two square roots and three iterative
// atan2 runs (shift normalize plus up to 20 CORDIC steps each), with one shared
// multiplier for the remaining products. An unreachable target skips the second
// square root and the atan2 runs and goes straight to the result.
// A finished result waits in the output register while the next item is taken.
// Registers (APB, byte address 4*i): 0 coxa_offset, 1 femur_length,
// 2 tibia_length, 14 bits each; write them only while the block is idle.

module leg_inverse_kinematics (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               operation,
    input  wire logic signed [15:0] target_x,
    input  wire logic signed [15:0] target_y,
    input  wire logic signed [15:0] lift_offset,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [8:0]       coxa_deg,
    output logic signed [8:0]       femur_deg,
    output logic signed [9:0]       tibia_servo_deg,
    output logic                    unreachable
);

    logic [13:0] coxa_reg, femur_reg, tibia_reg;
    logic        wr_en;
    lik_pkg::cmd_t    cmd;
    lik_pkg::status_t status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coxa_reg  <= '0;
            femur_reg <= '0;
            tibia_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                lik_pkg::REG_COXA:  coxa_reg  <= pwdata[13:0];
                lik_pkg::REG_FEMUR: femur_reg <= pwdata[13:0];
                lik_pkg::REG_TIBIA: tibia_reg <= pwdata[13:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            lik_pkg::REG_COXA:  prdata = {18'b0, coxa_reg};
            lik_pkg::REG_FEMUR: prdata = {18'b0, femur_reg};
            lik_pkg::REG_TIBIA: prdata = {18'b0, tibia_reg};
            default:            prdata = '0;
        endcase
    end

    lik_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    lik_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .operation       (operation),
        .target_x        (target_x),
        .target_y        (target_y),
        .lift_offset     (lift_offset),
        .coxa_offset     (coxa_reg),
        .femur_length    (femur_reg),
        .tibia_length    (tibia_reg),
        .coxa_deg        (coxa_deg),
        .femur_deg       (femur_deg),
        .tibia_servo_deg (tibia_servo_deg),
        .unreachable     (unreachable)
    );

endmodule

`default_nettype wire

### verif/testbench.sv
// Testbench for leg_inverse_kinematics: directed table plus random targets against a predictor.
`timescale 1ns / 1ps

module testbench;

    localparam longint ONE_DEG = 65536;
    localparam int LIMIT = 4000000;
    localparam int SETTLE = 300;

    typedef struct packed {
        logic signed [8:0] coxa;
        logic signed [8:0] femur;
        logic signed [9:0] tibia;
        logic              unreach;
    } angles_t;

    typedef struct {
        bit              cfg;      // row rewrites the registers instead of sending
        bit              op;
        shortint         x, y, lift;
        int              coxa, fem, tib;
        bit              typed;
        angles_t         want;
    } row_t;

    logic clk = 0, rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0, in_ready;
    logic operation = 0;
    logic signed [15:0] target_x = 0, target_y = 0, lift_offset = 0;
    logic out_valid, out_ready = 0;
    logic signed [8:0] coxa_deg, femur_deg;
    logic signed [9:0] tibia_servo_deg;
    logic unreachable;

    leg_inverse_kinematics dut (.*);

    always begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // predictor state
    longint leg_coxa, leg_femur, leg_tibia;
    longint foot_x, foot_y;
    angles_t held;

    angles_t angle_q[$];
    int errors = 0;
    int cycles = 0;
    bit stress = 0;
    row_t rows[$];

    function automatic longint isqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint atan_step(int i);
        longint t[20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                          29, 14, 7};
        return t[i];
    endfunction

    function automatic longint octant_angle(longint big, longint sml);
        longint cx, cy, z, nx;
        int i;
        z = 0;
        while (big >= (64'sd1 << 30)) begin
            big >>= 1;
            sml >>= 1;
        end
        while (big < (64'sd1 << 29)) begin
            big <<= 1;
            sml <<= 1;
        end
        cx = big;
        cy = sml;
        for (i = 0; i < 20 && cy != 0; i++) begin
            if (cy > 0) begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z += atan_step(i);
            end
            else begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z -= atan_step(i);
            end
            cx = nx;
        end
        if (z < 0) z = 0;
        if (z > 45 * ONE_DEG) z = 45 * ONE_DEG;
        return z;
    endfunction

    function automatic longint vec_angle(longint y, longint x);
        longint ax, ay, big, sml, a;
        if (x == 0 && y == 0) return 0;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        big = ax >= ay ? ax : ay;
        sml = ax >= ay ? ay : ax;
        if (sml == 0) a = 0;
        else if (sml == big) a = 45 * ONE_DEG;
        else a = octant_angle(big, sml);
        if (ay > ax) a = 90 * ONE_DEG - a;
        if (x < 0) a = 180 * ONE_DEG - a;
        if (y < 0) a = -a;
        return a;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic angles_t solve_leg(bit op, longint tx, longint ty, longint v);
        longint r, h, d, f2, t2, sp2, sm2, c, s, fx, fy, fem, tib;
        bit miss;
        angles_t res;
        if (op) begin
            foot_x = clamp16(foot_x + tx);
            foot_y = clamp16(foot_y + ty);
        end
        else begin
            foot_x = tx;
            foot_y = ty;
        end
        r = isqrt(foot_x * foot_x + foot_y * foot_y);
        h = r - leg_coxa;
        if (h < 0) h = -h;
        d = h * h + v * v;
        f2 = leg_femur * leg_femur;
        t2 = leg_tibia * leg_tibia;
        sp2 = (leg_femur + leg_tibia) * (leg_femur + leg_tibia);
        sm2 = (leg_femur - leg_tibia) * (leg_femur - leg_tibia);
        miss = (d == 0) || (d > sp2) || (d < sm2);
        if (!miss) begin
            s = isqrt((sp2 - d) * (d - sm2));
            c = d + f2 - t2;
            if (h > 0 && s > 0) begin
                fx = h * c - v * s;
                fy = v * c + h * s;
            end
            else begin
                fx = h * c + v * s;
                fy = v * c - h * s;
            end
            fem = vec_angle(fy, fx);
            tib = vec_angle(2 * d * v - fy, 2 * d * h - fx) + 180 * ONE_DEG - fem;
            held.coxa = 9'(vec_angle(foot_y, foot_x) / ONE_DEG);
            held.femur = 9'(fem / ONE_DEG);
            held.tibia = 10'(90 - tib / ONE_DEG);
        end
        res = held;
        res.unreach = miss;
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        angles_t e;
        if (rst_n && out_valid && out_ready) begin
            if (angle_q.size() == 0) report("unexpected transaction", 0, 0);
            else begin
                e = angle_q.pop_front();
                if (coxa_deg !== e.coxa) report("coxa_deg", coxa_deg, e.coxa);
                if (femur_deg !== e.femur) report("femur_deg", femur_deg, e.femur);
                if (tibia_servo_deg !== e.tibia)
                    report("tibia_servo_deg", tibia_servo_deg, e.tibia);
                if (unreachable !== e.unreach) report("unreachable", unreachable, e.unreach);
            end
        end
    end

    // receiver: random stalls, one long hold-off once random traffic starts
    initial begin
        bit held_off;
        int n;
        held_off = 0;
        forever begin
            @(negedge clk);
            if (stress && !held_off) begin
                held_off = 1;
                out_ready = 0;
                repeat (3000) @(negedge clk);
            end
            n = $urandom_range(0, 99);
            if (n < 60) out_ready = 1;
            else if (n < 95) begin
                out_ready = 0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_ready = 1;
            end
            else begin
                out_ready = 0;
                repeat ($urandom_range(20, 60)) @(negedge clk);
                out_ready = 1;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, int val);
        @(negedge clk);
        psel = 1;
        pwrite = 1;
        penable = 0;
        paddr = {idx, 2'b00};
        pwdata = 32'(val);
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic set_leg(int cx, int fm, int tb);
        @(negedge clk);
        in_valid = 0;
        while (angle_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        write_reg(lik_pkg::REG_COXA, cx);
        write_reg(lik_pkg::REG_FEMUR, fm);
        write_reg(lik_pkg::REG_TIBIA, tb);
        leg_coxa = cx;
        leg_femur = fm;
        leg_tibia = tb;
    endtask

    task automatic send(bit op, longint x, longint y, longint l, bit typed, angles_t want);
        int n;
        angles_t p;
        @(negedge clk);
        in_valid = 1;
        operation = op;
        target_x = 16'(x);
        target_y = 16'(y);
        lift_offset = 16'(l);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        p = solve_leg(op, x, y, l);
        angle_q.push_back(typed ? want : p);
        n = $urandom_range(0, 99);
        if (n >= 70) begin
            @(negedge clk);
            in_valid = 0;
            if (n < 95) repeat ($urandom_range(0, 4)) @(negedge clk);
            else repeat ($urandom_range(20, 60)) @(negedge clk);
        end
    endtask

    function automatic void add(bit op, int x, int y, int l);
        row_t r;
        r = '{default: 0};
        r.op = op; r.x = 16'(x); r.y = 16'(y); r.lift = 16'(l);
        rows.push_back(r);
    endfunction

    function automatic void add_miss(bit op, int x, int y, int l);
        row_t r;
        r = '{default: 0};
        r.op = op; r.x = 16'(x); r.y = 16'(y); r.lift = 16'(l);
        r.typed = 1;
        r.want = '{coxa: 0, femur: 0, tibia: 0, unreach: 1};
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(int cx, int fm, int tb);
        row_t r;
        r = '{default: 0};
        r.cfg = 1; r.coxa = cx; r.fem = fm; r.tib = tb;
        rows.push_back(r);
    endfunction

    function automatic longint s16(real v);
        return clamp16(longint'($rtoi(v)));
    endfunction

    // random target aimed at the leg's workspace
    task automatic send_reachable();
        real reach, phi, th, r;
        int lo, hi;
        lo = int'(leg_femur > leg_tibia ? leg_femur - leg_tibia : leg_tibia - leg_femur);
        hi = int'(leg_femur + leg_tibia);
        reach = $urandom_range(lo + 1, hi);
        phi = ($urandom_range(0, 10000) / 10000.0 - 0.5) * 3.14159;
        th = ($urandom_range(0, 10000) / 10000.0 - 0.5) * 2.0 * 3.14159;
        r = leg_coxa + ($urandom_range(0, 3) == 0 ? -1.0 : 1.0) * reach * $cos(phi);
        if (r < 0) r = -r;
        send(0, s16(r * $cos(th)), s16(r * $sin(th)), s16(reach * $sin(phi)), 0, '0);
    endtask

    initial begin
        int k, ph, n;
        leg_coxa = 0; leg_femur = 0; leg_tibia = 0;
        foot_x = 0; foot_y = 0;
        held = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // zero-length leg: everything misses, last angles stay zero
        add_cfg(0, 0, 0);
        add_miss(0, 0, 0, 0);
        add_miss(0, 32767, 32767, 32767);
        add_miss(1, 32767, -32768, -32768);
        add_miss(1, 32767, -32768, 0);
        add_miss(0, -32768, -32768, -32768);
        add_cfg(0, 1000, 1000);
        add(0, 1000, 0, 0);
        add(0, 0, 1000, -500);
        add(0, -1414, 0, 0);
        add(0, 0, 0, 1000);
        add(0, 1000, 1000, 0);
        add(0, -1000, -1000, 200);
        add(1, 100, 0, 0);
        add(1, -200, 50, -100);
        add(0, 3000, 0, 0);
        add(0, 1999, 0, 0);
        add(0, 0, -1500, 300);
        add(0, 10, 0, -1990);
        add(0, 10, 0, 1990);
        add_cfg(16383, 16383, 16383);
        add(0, 0, 0, 0);
        add(0, 16383, 0, 16383);
        add(0, -32768, 0, 0);
        add(1, 32767, 32767, -20000);

        foreach (rows[i]) begin
            if (rows[i].cfg) set_leg(rows[i].coxa, rows[i].fem, rows[i].tib);
            else send(rows[i].op, rows[i].x, rows[i].y, rows[i].lift,
                      rows[i].typed, rows[i].want);
        end

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_leg(0, 16383, 16383);
                1: set_leg(16383, 16383, 1);
                2: set_leg(500, 1200, 800);
                default: set_leg($urandom_range(0, 16383), $urandom_range(1, 16383),
                                 $urandom_range(1, 16383));
            endcase
            // long receiver hold-off starts while items keep coming
            if (ph == 0) stress = 1;
            for (k = 0; k < 290; k++) begin
                n = $urandom_range(0, 99);
                if (n < 75) send_reachable();
                else if (n < 90)
                    send(1, $signed(16'($urandom_range(0, 511))) - 256,
                         $signed(16'($urandom_range(0, 511))) - 256,
                         $signed(16'($urandom)), 0, '0);
                else
                    send(1'($urandom_range(0, 1)), $signed(16'($urandom)),
                         $signed(16'($urandom)), $signed(16'($urandom)), 0, '0);
            end
        end
        @(negedge clk);
        in_valid = 0;

        while (angle_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/lik_pkg.sv
src/lik_sqrt.sv
src/lik_atan.sv
src/lik_datapath.sv
src/lik_ctrl.sv
src/leg_inverse_kinematics.sv
verif/testbench.sv
